// ===== rtl/core/assert_macros.svh =====
// Assertion helpers included by the sequencer top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/bss_pkg.sv =====
package bss_pkg;

    localparam logic [2:0] MODE_STOP      = 3'd0;
    localparam logic [2:0] MODE_OPEN_FW   = 3'd1;
    localparam logic [2:0] MODE_OPEN_RV   = 3'd2;
    localparam logic [2:0] MODE_CLOSED_FW = 3'd3;
    localparam logic [2:0] MODE_CLOSED_RV = 3'd4;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_MODE = 2'd1;
    localparam logic [1:0] ACT_HALL = 2'd2;

    localparam logic [2:0] REG_CONST_START  = 3'd0;
    localparam logic [2:0] REG_CONST_TARGET = 3'd1;
    localparam logic [2:0] REG_CONST_RAMP   = 3'd2;
    localparam logic [2:0] REG_FLY_START    = 3'd3;
    localparam logic [2:0] REG_FLY_TARGET   = 3'd4;
    localparam logic [2:0] REG_FLY_RAMP     = 3'd5;
    localparam logic [2:0] REG_DUTY         = 3'd6;

    localparam logic [9:0] DUTY_MIN   = 10'd20;
    localparam logic [9:0] DUTY_MAX   = 10'd980;
    localparam logic [9:0] DUTY_BRAKE = 10'd980;
    localparam logic [9:0] DUTY_RESET = 10'd800;
    localparam logic [9:0] US_PER_MS  = 10'd1000;

    // controller -> datapath commands
    typedef struct packed {
        logic latch_in;    // capture input item
        logic mode_set;    // apply a set-mode command (start ramp)
        logic mul_start;   // latch elapsed, span and direction
        logic div_start;   // form span*elapsed, kick serial divider
        logic interp;      // interval_now from quotient or target
        logic commutate;   // compare and maybe step
        logic hall_step;   // step from Hall table
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic div_busy;
        logic ramp_active; // elapsed < total
        logic due;         // commutation interval elapsed
    } t_sts;

    function automatic logic [2:0] hall_fw(input logic [2:0] h);
        case (h)
            3'd1: hall_fw = 3'd5;
            3'd2: hall_fw = 3'd3;
            3'd3: hall_fw = 3'd4;
            3'd4: hall_fw = 3'd1;
            3'd6: hall_fw = 3'd2;
            default: hall_fw = 3'd0;
        endcase
    endfunction

    function automatic logic [2:0] hall_rv(input logic [2:0] h);
        case (h)
            3'd1: hall_rv = 3'd2;
            3'd3: hall_rv = 3'd1;
            3'd4: hall_rv = 3'd4;
            3'd5: hall_rv = 3'd3;
            3'd6: hall_rv = 3'd5;
            default: hall_rv = 3'd0;
        endcase
    endfunction

endpackage

// ===== rtl/core/bldc_six_step_ramp_sequencer.sv =====
// Six-step BLDC sequencer with open-loop ramp start and Hall handover.
// Set-mode and Hall items pass a pending step; a ramp tick runs the multiply,
// divide, interpolate and commutate states, the one-bit-per-cycle divider
// scaling span*elapsed by ramp time. Items wait for idle and no pending output.
`include "assert_macros.svh"
module bldc_six_step_ramp_sequencer import bss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_new_mode,
    input  logic [31:0] i_now_us,
    input  logic [2:0]  i_hall_code,
    input  logic        i_stalled,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_drive_kind,
    output logic [2:0]  o_step_index,
    output logic [9:0]  o_duty_out,
    output logic [2:0]  o_mode_now,
    output logic        o_hall_phase
);

    logic [31:0] r_cs, r_ct, r_fs, r_ft;
    logic [15:0] r_cr, r_fr;
    logic [9:0]  r_duty;
    logic        wr;
    logic [2:0]  idx;
    t_cmd        cmd, cmd_dp;
    t_sts        sts;
    logic [2:0]  mode, step;
    logic        fw, pend_q;
    logic [2:0]  nm_q;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs <= '0; r_ct <= '0; r_cr <= '0; r_fs <= '0; r_ft <= '0; r_fr <= '0;
            r_duty <= DUTY_RESET;
        end else if (wr) begin
            unique case (idx)
                REG_CONST_START:  r_cs <= pwdata;
                REG_CONST_TARGET: r_ct <= pwdata;
                REG_CONST_RAMP:   r_cr <= pwdata[15:0];
                REG_FLY_START:    r_fs <= pwdata;
                REG_FLY_TARGET:   r_ft <= pwdata;
                REG_FLY_RAMP:     r_fr <= pwdata[15:0];
                REG_DUTY: r_duty <= (pwdata[9:0] < DUTY_MIN) ? DUTY_MIN :
                                    (pwdata[9:0] > DUTY_MAX) ? DUTY_MAX : pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CONST_START:  prdata = r_cs;
            REG_CONST_TARGET: prdata = r_ct;
            REG_CONST_RAMP:   prdata = {16'd0, r_cr};
            REG_FLY_START:    prdata = r_fs;
            REG_FLY_TARGET:   prdata = r_ft;
            REG_FLY_RAMP:     prdata = {16'd0, r_fr};
            REG_DUTY:         prdata = {22'd0, r_duty};
            default:          prdata = '0;
        endcase
    end

    // set-mode / Hall apply toward the datapath, delayed to the cycle after accept
    logic [1:0] act_q;
    logic       acc_q;
    logic [2:0] mode_before;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc_q <= 1'b0;
        end else begin
            acc_q <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                act_q <= i_action; nm_q <= i_new_mode; mode_before <= mode;
            end
        end
    end
    assign pend_q = acc_q;

    always_comb begin
        cmd_dp = cmd;
        cmd_dp.mode_set  = pend_q && act_q == ACT_MODE && nm_q != MODE_STOP
                           && nm_q <= MODE_CLOSED_RV && nm_q != mode_before;
        cmd_dp.hall_step = pend_q && act_q == ACT_HALL && mode == mode_before
                           && o_stall && !(cmd_dp.mode_set);
    end

    bss_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_action, .i_new_mode, .i_hall_code, .i_stalled,
        .i_sts(sts), .i_step(step), .o_cmd(cmd), .o_mode(mode), .o_fw(fw),
        .o_out_valid(o_valid), .i_out_stall(i_stall), .o_drive_kind,
        .o_step_index, .o_mode_now, .o_hall_phase
    );

    bss_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd_dp), .o_sts(sts), .i_mode(mode), .i_fw(fw),
        .i_new_mode(nm_q), .i_now_us, .i_hall_code,
        .i_cst_start(r_cs), .i_cst_target(r_ct), .i_cst_ramp(r_cr),
        .i_fly_start(r_fs), .i_fly_target(r_ft), .i_fly_ramp(r_fr),
        .o_step(step)
    );

    assign o_duty_out = o_drive_kind ? DUTY_BRAKE : r_duty;

    `ASSERT_IMPL(a_stall_out, i_clk, i_rst_n, o_valid, o_stall)
    `ASSERT_IMPL(a_brake_stop, i_clk, i_rst_n, o_valid && o_drive_kind, o_mode_now == MODE_STOP)
    `ASSERT_IMPL(a_step_range, i_clk, i_rst_n, o_valid, o_step_index <= 3'd5)

endmodule

// ===== rtl/core/bss_datapath.sv =====
module bss_datapath import bss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [2:0]  i_mode,
    input  logic        i_fw,
    input  logic [2:0]  i_new_mode,
    input  logic [31:0] i_now_us,
    input  logic [2:0]  i_hall_code,
    input  logic [31:0] i_cst_start,
    input  logic [31:0] i_cst_target,
    input  logic [15:0] i_cst_ramp,
    input  logic [31:0] i_fly_start,
    input  logic [31:0] i_fly_target,
    input  logic [15:0] i_fly_ramp,
    output logic [2:0]  o_step
);

    logic [31:0] r_now, r_begin, r_last, r_interval;
    logic [31:0] r_start, r_target;
    logic [2:0]  r_hall, r_step;
    logic [25:0] r_total;
    logic [31:0] r_elapsed;
    logic [63:0] r_prod;
    logic [31:0] r_span;
    logic        r_up;
    // serial restoring divider
    logic [63:0] r_quo;
    logic [26:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;

    logic [31:0] n_elapsed;
    logic [26:0] n_trial;
    logic [32:0] n_since;

    assign n_elapsed = r_now - r_begin;
    assign n_trial   = {r_rem[25:0], r_quo[63]};
    assign n_since   = {1'b0, r_now - r_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin <= '0; r_last <= '0; r_interval <= '0; r_step <= '0;
            r_start <= '0; r_target <= '0; r_total <= '0;
            r_busy <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_cmd.latch_in) begin
                r_now  <= i_now_us;
                r_hall <= i_hall_code;
            end
            // ramp start: latch the register set for the new mode
            if (i_cmd.mode_set) begin
                if (i_new_mode == MODE_OPEN_FW || i_new_mode == MODE_OPEN_RV) begin
                    r_start <= i_cst_start; r_target <= i_cst_target;
                    r_interval <= i_cst_start;
                    r_total <= 26'(i_cst_ramp) * 26'(US_PER_MS);
                end else begin
                    r_start <= i_fly_start; r_target <= i_fly_target;
                    r_interval <= i_fly_start;
                    r_total <= 26'(i_fly_ramp) * 26'(US_PER_MS);
                end
                r_begin <= r_now;
                r_last  <= r_now;
                r_step  <= '0;
            end
            if (i_cmd.mul_start) begin
                r_elapsed <= n_elapsed;
                r_up      <= r_target > r_start;
                r_span    <= (r_target > r_start) ? r_target - r_start : r_start - r_target;
            end
            if (i_cmd.div_start) begin
                r_prod <= r_span * r_elapsed;
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_rem  <= '0;
            end else if (r_busy && r_cnt == 7'd0) begin
                r_quo <= r_prod;
                r_cnt <= 7'd1;
            end else if (r_busy) begin
                // one quotient bit per cycle
                if (n_trial >= {1'b0, r_total}) begin
                    r_rem <= n_trial - {1'b0, r_total};
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                if (r_cnt == 7'd64) r_busy <= 1'b0;
                r_cnt <= r_cnt + 7'd1;
            end
            if (i_cmd.interp) begin
                if (!o_sts.ramp_active) r_interval <= r_target;
                else if (r_up)         r_interval <= r_start + r_quo[31:0];
                else                   r_interval <= r_start - r_quo[31:0];
            end
            if (i_cmd.commutate && o_sts.due) begin
                r_last <= r_now;
                if (i_fw) r_step <= (r_step == 3'd5) ? 3'd0 : r_step + 3'd1;
                else      r_step <= (r_step == 3'd0) ? 3'd5 : r_step - 3'd1;
            end
            if (i_cmd.hall_step)
                r_step <= (i_mode == MODE_CLOSED_FW) ? hall_fw(r_hall) : hall_rv(r_hall);
        end
    end

    assign o_sts.div_busy    = r_busy || i_cmd.div_start;
    assign o_sts.ramp_active = {6'd0, n_elapsed} < {12'd0, r_total};
    assign o_sts.due         = n_since >= {1'b0, r_interval};
    assign o_step            = r_step;

endmodule

// ===== rtl/core/bss_ctrl.sv =====
module bss_ctrl import bss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_action,
    input  logic [2:0] i_new_mode,
    input  logic [2:0] i_hall_code,
    input  logic       i_stalled,
    input  t_sts       i_sts,
    input  logic [2:0] i_step,
    output t_cmd       o_cmd,
    output logic [2:0] o_mode,
    output logic       o_fw,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_drive_kind,
    output logic [2:0] o_step_index,
    output logic [2:0] o_mode_now,
    output logic       o_hall_phase
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_DIV  = 6'b000100,
        S_WAIT = 6'b001000,
        S_CMP  = 6'b010000,
        S_HAND = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_mode;
    logic       r_closed, r_fault;
    logic       r_ovalid, r_brake;
    logic       r_hall_pend;
    logic [2:0] r_omode;
    logic       r_ophase;

    logic accept;
    logic is_closed;

    assign accept    = i_valid && !o_stall;
    assign o_stall   = (r_state != S_IDLE) || r_ovalid || r_hall_pend;
    assign is_closed = (r_mode == MODE_CLOSED_FW) || (r_mode == MODE_CLOSED_RV);
    assign o_mode    = r_mode;
    assign o_fw      = (r_mode == MODE_OPEN_FW) || (r_mode == MODE_CLOSED_FW);

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.latch_in = accept;
        o_cmd.mul_start = (r_state == S_MUL);
        o_cmd.div_start = (r_state == S_DIV);
        o_cmd.interp    = (r_state == S_CMP);
        o_cmd.commutate = (r_state == S_HAND);
        o_cmd.mode_set  = 1'b0;
        o_cmd.hall_step = 1'b0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && i_action == ACT_TICK && !(r_fault && r_mode != MODE_STOP)
                        && (r_mode != MODE_STOP) && !(is_closed && r_closed))
                        n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  n_state = S_WAIT;
            S_WAIT: if (!i_sts.div_busy) n_state = S_CMP;
            S_CMP:  n_state = S_HAND;
            S_HAND: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_mode <= MODE_STOP; r_closed <= 1'b0;
            r_fault <= 1'b0; r_ovalid <= 1'b0; r_hall_pend <= 1'b0;
            r_brake <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            r_hall_pend <= 1'b0;
            // pending cycle: mode set or Hall step lands in the datapath
            if (r_hall_pend) begin
                r_ovalid <= 1'b1;
                r_omode <= r_mode; r_ophase <= r_closed;
            end
            if (accept) begin
                unique case (i_action)
                    ACT_MODE: if (i_new_mode <= MODE_CLOSED_RV && i_new_mode != r_mode) begin
                        r_mode <= i_new_mode; r_closed <= 1'b0;
                        r_hall_pend <= 1'b1;
                        r_brake <= (i_new_mode == MODE_STOP);
                    end
                    ACT_HALL: if (is_closed && r_closed) begin
                        if (i_hall_code == 3'd0 || i_hall_code == 3'd7) begin
                            r_fault <= 1'b1;
                        end else begin
                            r_hall_pend <= 1'b1;
                            r_brake <= 1'b0;
                        end
                    end
                    ACT_TICK: begin
                        if (r_fault) r_fault <= 1'b0;
                        if ((r_fault && r_mode != MODE_STOP) ||
                            (is_closed && r_closed && i_stalled)) begin
                            r_mode <= MODE_STOP; r_closed <= 1'b0;
                            r_ovalid <= 1'b1; r_brake <= 1'b1;
                            r_omode <= MODE_STOP; r_ophase <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == S_HAND) begin
                if (is_closed && !i_sts.ramp_active) r_closed <= 1'b1;
                if (i_sts.due) begin
                    r_ovalid <= 1'b1; r_brake <= 1'b0; r_omode <= r_mode;
                    r_ophase <= r_closed || (is_closed && !i_sts.ramp_active);
                end
            end
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_drive_kind = r_brake;
    assign o_step_index = r_brake ? 3'd0 : i_step;
    assign o_mode_now   = r_omode;
    assign o_hall_phase = r_ophase;

endmodule
